>>> sv/bpc_pkg.sv
// Shared types and constants of the barometer pressure compensation block.
package bpc_pkg;

	localparam int RAW_W   = 24;
	localparam int COEFF_W = 16;
	localparam int INDEX_W = 3;
	localparam int TEMP_W  = 20;
	localparam int PRESS_W = 32;
	localparam int ACC_W   = 40;
	localparam int MUL_W   = 27;
	localparam int PROD_W  = 2 * MUL_W;

	localparam int OFF_SHIFT    = 7;
	localparam int SENS_SHIFT   = 8;
	localparam int TEMP_SHIFT   = 23;
	localparam int T2_SHIFT     = 31;
	localparam int P_SENS_SHIFT = 21;
	localparam int P_SHIFT      = 15;
	localparam int SENS_SPLIT   = 20;

	localparam logic signed [20:0] TEMP_BASE  = 21'sd2000;
	localparam logic signed [20:0] TEMP_VLO   = 21'sd1500;

	typedef enum logic [INDEX_W-1:0] {
		REG_SENS        = 3'd0,
		REG_OFFSET      = 3'd1,
		REG_SENS_TEMP   = 3'd2,
		REG_OFFSET_TEMP = 3'd3,
		REG_REF_TEMP    = 3'd4,
		REG_TEMP_SLOPE  = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_DT,
		OP_MUL_OFF,
		OP_MUL_SENS,
		OP_MUL_TEMP,
		OP_MUL_DT2,
		OP_MUL_LO2,
		OP_MUL_VLO2,
		OP_CORR,
		OP_TEMP_FIN,
		OP_P_MUL_LO,
		OP_P_MUL_HI,
		OP_P_ACC,
		OP_P_SCALE,
		OP_P_SUB,
		OP_P_FIN
	} dp_op_t;

	typedef struct packed {
		logic   load;
		logic   emit;
		dp_op_t op;
	} dp_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL_OFF,
		ST_MUL_SENS,
		ST_MUL_TEMP,
		ST_MUL_DT2,
		ST_MUL_LO2,
		ST_MUL_VLO2,
		ST_CORR,
		ST_TEMP_FIN,
		ST_P_MUL_LO,
		ST_P_MUL_HI,
		ST_P_ACC,
		ST_P_SCALE,
		ST_P_SUB,
		ST_P_FIN,
		ST_DONE
	} ctrl_state_t;

endpackage

>>> sv/bpc_if.sv
// Channel interfaces of the barometer pressure compensation block.
interface bpc_sample_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [bpc_pkg::RAW_W-1:0]   raw_value;
	modport source(output valid, kind, raw_value, input ready);
	modport sink(input valid, kind, raw_value, output ready);
endinterface

interface bpc_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [bpc_pkg::TEMP_W-1:0]  temperature_x100;
	logic signed [bpc_pkg::PRESS_W-1:0] pressure_x100;
	modport source(output valid, temperature_x100, pressure_x100, input ready);
	modport sink(input valid, temperature_x100, pressure_x100, output ready);
endinterface

interface bpc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bpc_pkg::INDEX_W-1:0]   index;
	logic [bpc_pkg::COEFF_W-1:0]   data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> sv/bpc_ctrl.sv
// Sequencing state machine and handshake control of the compensation block.
module bpc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	bpc_sample_if.sink          sample,
	bpc_result_if.source        result,
	input  logic                is_pressure,
	output bpc_pkg::dp_cmd_t    cmd
);

	bpc_pkg::ctrl_state_t state_q;
	bpc_pkg::ctrl_state_t state_next;
	logic                 out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid = out_valid_q;
	assign sample.ready = (state_q == bpc_pkg::ST_IDLE);

	always_comb begin
		state_next = state_q;
		cmd.load   = 1'b0;
		cmd.emit   = 1'b0;
		cmd.op     = bpc_pkg::OP_NONE;
		case (state_q)
			bpc_pkg::ST_IDLE: begin
				if (sample.valid) begin
					cmd.load   = 1'b1;
					state_next = bpc_pkg::ST_DECODE;
				end
			end
			bpc_pkg::ST_DECODE: begin
				cmd.op     = bpc_pkg::OP_DT;
				state_next = is_pressure ? bpc_pkg::ST_P_MUL_LO : bpc_pkg::ST_MUL_OFF;
			end
			bpc_pkg::ST_MUL_OFF: begin
				cmd.op     = bpc_pkg::OP_MUL_OFF;
				state_next = bpc_pkg::ST_MUL_SENS;
			end
			bpc_pkg::ST_MUL_SENS: begin
				cmd.op     = bpc_pkg::OP_MUL_SENS;
				state_next = bpc_pkg::ST_MUL_TEMP;
			end
			bpc_pkg::ST_MUL_TEMP: begin
				cmd.op     = bpc_pkg::OP_MUL_TEMP;
				state_next = bpc_pkg::ST_MUL_DT2;
			end
			bpc_pkg::ST_MUL_DT2: begin
				cmd.op     = bpc_pkg::OP_MUL_DT2;
				state_next = bpc_pkg::ST_MUL_LO2;
			end
			bpc_pkg::ST_MUL_LO2: begin
				cmd.op     = bpc_pkg::OP_MUL_LO2;
				state_next = bpc_pkg::ST_MUL_VLO2;
			end
			bpc_pkg::ST_MUL_VLO2: begin
				cmd.op     = bpc_pkg::OP_MUL_VLO2;
				state_next = bpc_pkg::ST_CORR;
			end
			bpc_pkg::ST_CORR: begin
				cmd.op     = bpc_pkg::OP_CORR;
				state_next = bpc_pkg::ST_TEMP_FIN;
			end
			bpc_pkg::ST_TEMP_FIN: begin
				cmd.op     = bpc_pkg::OP_TEMP_FIN;
				state_next = bpc_pkg::ST_DONE;
			end
			bpc_pkg::ST_P_MUL_LO: begin
				cmd.op     = bpc_pkg::OP_P_MUL_LO;
				state_next = bpc_pkg::ST_P_MUL_HI;
			end
			bpc_pkg::ST_P_MUL_HI: begin
				cmd.op     = bpc_pkg::OP_P_MUL_HI;
				state_next = bpc_pkg::ST_P_ACC;
			end
			bpc_pkg::ST_P_ACC: begin
				cmd.op     = bpc_pkg::OP_P_ACC;
				state_next = bpc_pkg::ST_P_SCALE;
			end
			bpc_pkg::ST_P_SCALE: begin
				cmd.op     = bpc_pkg::OP_P_SCALE;
				state_next = bpc_pkg::ST_P_SUB;
			end
			bpc_pkg::ST_P_SUB: begin
				cmd.op     = bpc_pkg::OP_P_SUB;
				state_next = bpc_pkg::ST_P_FIN;
			end
			bpc_pkg::ST_P_FIN: begin
				cmd.op     = bpc_pkg::OP_P_FIN;
				state_next = bpc_pkg::ST_DONE;
			end
			bpc_pkg::ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					cmd.emit   = 1'b1;
					state_next = bpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = bpc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/bpc_datapath.sv
// Calibration registers, shared multiplier and compensation arithmetic.
module bpc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	bpc_cfg_if.sink                             cfg,
	input  bpc_pkg::dp_cmd_t                    cmd,
	input  logic                                kind,
	input  logic [bpc_pkg::RAW_W-1:0]           raw_value,
	output logic                                is_pressure,
	output logic signed [bpc_pkg::TEMP_W-1:0]   temperature_x100,
	output logic signed [bpc_pkg::PRESS_W-1:0]  pressure_x100
);

	// Signed shift that rounds toward zero, as a C division by a power of two.
	function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] x,
		input int unsigned k);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

	logic [bpc_pkg::COEFF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

	logic                                 kind_q;
	logic [bpc_pkg::RAW_W-1:0]            raw_q;
	logic signed [25:0]                   dt_q;
	logic signed [bpc_pkg::PROD_W-1:0]    prod_q;
	logic signed [40:0]                   off_q;
	logic signed [40:0]                   sens_q;
	logic signed [bpc_pkg::TEMP_W-1:0]    temp_q;
	logic [17:0]                          tcorr_q;
	logic [39:0]                          off_corr_q;
	logic [39:0]                          sens_corr_q;
	logic signed [63:0]                   acc_q;

	logic signed [bpc_pkg::ACC_W-1:0]     offset_acc_q;
	logic signed [bpc_pkg::ACC_W-1:0]     sens_acc_q;
	logic signed [bpc_pkg::TEMP_W-1:0]    temp_reg_q;
	logic signed [bpc_pkg::PRESS_W-1:0]   press_reg_q;
	logic signed [bpc_pkg::TEMP_W-1:0]    out_temp_q;
	logic signed [bpc_pkg::PRESS_W-1:0]   out_press_q;

	logic signed [bpc_pkg::MUL_W-1:0]     mul_a;
	logic signed [bpc_pkg::MUL_W-1:0]     mul_b;
	logic signed [63:0]                   prod64;
	logic signed [63:0]                   div_off;
	logic signed [63:0]                   div_sens;
	logic signed [63:0]                   div_temp;
	logic signed [63:0]                   div_psens;
	logic signed [63:0]                   div_press;
	logic signed [20:0]                   lo_s;
	logic signed [20:0]                   vlo_s;
	logic [39:0]                          sq40;
	logic [39:0]                          five_sq;
	logic [39:0]                          seven_sq;
	logic [39:0]                          eleven_sq;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				bpc_pkg::REG_SENS:        c1_q <= cfg.data;
				bpc_pkg::REG_OFFSET:      c2_q <= cfg.data;
				bpc_pkg::REG_SENS_TEMP:   c3_q <= cfg.data;
				bpc_pkg::REG_OFFSET_TEMP: c4_q <= cfg.data;
				bpc_pkg::REG_REF_TEMP:    c5_q <= cfg.data;
				bpc_pkg::REG_TEMP_SLOPE:  c6_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign prod64    = {{(64 - bpc_pkg::PROD_W){prod_q[bpc_pkg::PROD_W-1]}}, prod_q};
	assign div_off   = shr_trunc(prod64, bpc_pkg::OFF_SHIFT);
	assign div_sens  = shr_trunc(prod64, bpc_pkg::SENS_SHIFT);
	assign div_temp  = shr_trunc(prod64, bpc_pkg::TEMP_SHIFT);
	assign div_psens = shr_trunc(acc_q, bpc_pkg::P_SENS_SHIFT);
	assign div_press = shr_trunc(acc_q, bpc_pkg::P_SHIFT);

	assign lo_s      = {temp_q[bpc_pkg::TEMP_W-1], temp_q} - bpc_pkg::TEMP_BASE;
	assign vlo_s     = {temp_q[bpc_pkg::TEMP_W-1], temp_q} + bpc_pkg::TEMP_VLO;
	assign sq40      = prod_q[39:0];
	assign five_sq   = (sq40 << 2) + sq40;
	assign seven_sq  = (sq40 << 3) - sq40;
	assign eleven_sq = (sq40 << 3) + (sq40 << 1) + sq40;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			bpc_pkg::OP_MUL_OFF: begin
				mul_a = {dt_q[25], dt_q};
				mul_b = {11'b0, c4_q};
			end
			bpc_pkg::OP_MUL_SENS: begin
				mul_a = {dt_q[25], dt_q};
				mul_b = {11'b0, c3_q};
			end
			bpc_pkg::OP_MUL_TEMP: begin
				mul_a = {dt_q[25], dt_q};
				mul_b = {11'b0, c6_q};
			end
			bpc_pkg::OP_MUL_DT2: begin
				mul_a = {dt_q[25], dt_q};
				mul_b = {dt_q[25], dt_q};
			end
			bpc_pkg::OP_MUL_LO2: begin
				mul_a = {{6{lo_s[20]}}, lo_s};
				mul_b = {{6{lo_s[20]}}, lo_s};
			end
			bpc_pkg::OP_MUL_VLO2: begin
				mul_a = {{6{vlo_s[20]}}, vlo_s};
				mul_b = {{6{vlo_s[20]}}, vlo_s};
			end
			bpc_pkg::OP_P_MUL_LO: begin
				mul_a = {3'b0, raw_q};
				mul_b = {7'b0, sens_acc_q[bpc_pkg::SENS_SPLIT-1:0]};
			end
			bpc_pkg::OP_P_MUL_HI: begin
				mul_a = {3'b0, raw_q};
				mul_b = {{7{sens_acc_q[bpc_pkg::ACC_W-1]}},
					sens_acc_q[bpc_pkg::ACC_W-1:bpc_pkg::SENS_SPLIT]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load) begin
			kind_q <= kind;
			raw_q  <= raw_value;
		end
		case (cmd.op)
			bpc_pkg::OP_DT: begin
				dt_q <= $signed({2'b0, raw_q}) - $signed({2'b0, c5_q, 8'b0});
			end
			bpc_pkg::OP_MUL_SENS: begin
				off_q <= $signed({9'b0, c2_q, 16'b0}) + div_off[40:0];
			end
			bpc_pkg::OP_MUL_TEMP: begin
				sens_q <= $signed({10'b0, c1_q, 15'b0}) + div_sens[40:0];
			end
			bpc_pkg::OP_MUL_DT2: begin
				temp_q <= bpc_pkg::TEMP_BASE[bpc_pkg::TEMP_W-1:0] +
					div_temp[bpc_pkg::TEMP_W-1:0];
			end
			bpc_pkg::OP_MUL_LO2: begin
				tcorr_q <= prod_q[bpc_pkg::T2_SHIFT+17:bpc_pkg::T2_SHIFT];
			end
			bpc_pkg::OP_MUL_VLO2: begin
				off_corr_q  <= five_sq >> 1;
				sens_corr_q <= five_sq >> 2;
			end
			bpc_pkg::OP_CORR: begin
				if (vlo_s[20]) begin
					off_corr_q  <= off_corr_q + seven_sq;
					sens_corr_q <= sens_corr_q + (eleven_sq >> 1);
				end
			end
			bpc_pkg::OP_P_MUL_HI: begin
				acc_q <= prod64;
			end
			bpc_pkg::OP_P_ACC: begin
				acc_q <= acc_q + (prod64 <<< bpc_pkg::SENS_SPLIT);
			end
			bpc_pkg::OP_P_SCALE: begin
				acc_q <= div_psens;
			end
			bpc_pkg::OP_P_SUB: begin
				acc_q <= acc_q - {{(64 - bpc_pkg::ACC_W){offset_acc_q[bpc_pkg::ACC_W-1]}},
					offset_acc_q};
			end
			default: ;
		endcase
		if (cmd.emit) begin
			out_temp_q  <= temp_reg_q;
			out_press_q <= press_reg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_acc_q <= '0;
			sens_acc_q   <= '0;
			temp_reg_q   <= '0;
			press_reg_q  <= '0;
		end else if (cmd.op == bpc_pkg::OP_TEMP_FIN) begin
			if (lo_s[20]) begin
				temp_reg_q   <= temp_q - $signed({2'b0, tcorr_q});
				offset_acc_q <= off_q[bpc_pkg::ACC_W-1:0] - off_corr_q;
				sens_acc_q   <= sens_q[bpc_pkg::ACC_W-1:0] - sens_corr_q;
			end else begin
				temp_reg_q   <= temp_q;
				offset_acc_q <= off_q[bpc_pkg::ACC_W-1:0];
				sens_acc_q   <= sens_q[bpc_pkg::ACC_W-1:0];
			end
		end else if (cmd.op == bpc_pkg::OP_P_FIN) begin
			press_reg_q <= div_press[bpc_pkg::PRESS_W-1:0];
		end
	end

	assign is_pressure      = kind_q;
	assign temperature_x100 = out_temp_q;
	assign pressure_x100    = out_press_q;

endmodule

>>> sv/barometer_pressure_compensation.sv
// Top level of the barometer pressure compensation block.
// Each accepted reading yields one result that holds the latest compensated
// temperature and pressure. Each reading runs through a sequence of steps
// on the single shared 27 by 27 bit multiplier, one product per cycle. A new
// reading is taken once the previous one has left the arithmetic, even while
// its result still waits in the output register.
module barometer_pressure_compensation (
	input  logic          clk,
	input  logic          arst_n,
	bpc_sample_if.sink    sample,
	bpc_result_if.source  result,
	bpc_cfg_if.sink       cfg
);

	bpc_pkg::dp_cmd_t cmd;
	logic             is_pressure;

	bpc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample),
		.result      (result),
		.is_pressure (is_pressure),
		.cmd         (cmd)
	);

	bpc_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd              (cmd),
		.kind             (sample.kind),
		.raw_value        (sample.raw_value),
		.is_pressure      (is_pressure),
		.temperature_x100 (result.temperature_x100),
		.pressure_x100    (result.pressure_x100)
	);

endmodule

>>> test/tb_barometer_pressure_compensation.sv
`timescale 1ns / 100ps
// Self-checking testbench of the barometer pressure compensation block.
module tb_barometer_pressure_compensation;
	import bpc_pkg::*;

	localparam logic KIND_TEMP  = 1'b0;
	localparam logic KIND_PRESS = 1'b1;
	localparam int NUM_CAL = REG_TEMP_SLOPE + 1;
	localparam logic [INDEX_W-1:0] FIRST_UNUSED_INDEX = INDEX_W'(REG_TEMP_SLOPE + 1);

	localparam longint RAW_MAX    = (longint'(1) << RAW_W) - 1;
	localparam longint TEMP_REF   = 2000;
	localparam longint TEMP_COLD  = -1500;
	localparam longint REF_SCALE  = 256;
	localparam longint SENS_SCALE = 32768;
	localparam longint OFF_SCALE  = 65536;
	localparam longint OFF_DIV    = longint'(1) << OFF_SHIFT;
	localparam longint SENS_DIV   = longint'(1) << SENS_SHIFT;
	localparam longint TEMP_DIV   = longint'(1) << TEMP_SHIFT;
	localparam longint T2_DIV     = longint'(1) << T2_SHIFT;
	localparam longint P_SENS_DIV = longint'(1) << P_SENS_SHIFT;
	localparam longint P_DIV      = longint'(1) << P_SHIFT;

	localparam int DIRECTED_N  = 23;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 250;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic signed [TEMP_W-1:0]  temp;
		logic signed [PRESS_W-1:0] press;
	} reading_result_t;

	typedef struct packed {
		logic            kind;
		logic [RAW_W-1:0] raw;
		logic [1:0]       cal_set;
		logic             typed;
		reading_result_t  res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	bpc_sample_if sample_ch ();
	bpc_result_if result_ch ();
	bpc_cfg_if    cfg_ch ();

	barometer_pressure_compensation u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	logic [COEFF_W-1:0]       cal [NUM_CAL];
	longint                   off_state;
	longint                   sens_state;
	logic signed [TEMP_W-1:0] temp_state;
	logic [PRESS_W-1:0]       press_state;

	reading_result_t pending_readings [$];
	stim_row_t       directed_rows [DIRECTED_N];
	logic [COEFF_W-1:0] cal_sets [3][NUM_CAL];

	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	int rx_gap = 0;
	bit gaps_on = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic reading_result_t compensate_reading(input logic kind_i,
			input logic [RAW_W-1:0] raw_i);
		longint dt, off, sens, temp, t_corr, off_corr, sens_corr, lo, vlo, t_fin, p;
		reading_result_t r;
		if (kind_i == KIND_TEMP) begin
			dt = longint'(raw_i) - longint'(cal[REG_REF_TEMP]) * REF_SCALE;
			off = longint'(cal[REG_OFFSET]) * OFF_SCALE
				+ (longint'(cal[REG_OFFSET_TEMP]) * dt) / OFF_DIV;
			sens = longint'(cal[REG_SENS]) * SENS_SCALE
				+ (longint'(cal[REG_SENS_TEMP]) * dt) / SENS_DIV;
			temp = TEMP_REF + (dt * longint'(cal[REG_TEMP_SLOPE])) / TEMP_DIV;
			t_corr = 0;
			off_corr = 0;
			sens_corr = 0;
			if (temp < TEMP_REF) begin
				lo = temp - TEMP_REF;
				t_corr = (dt * dt) / T2_DIV;
				off_corr = (5 * lo * lo) / 2;
				sens_corr = off_corr / 2;
				if (temp < TEMP_COLD) begin
					vlo = temp - TEMP_COLD;
					off_corr = off_corr + 7 * vlo * vlo;
					sens_corr = sens_corr + (11 * vlo * vlo) / 2;
				end
			end
			t_fin = temp - t_corr;
			temp_state = t_fin[TEMP_W-1:0];
			off_state = off - off_corr;
			sens_state = sens - sens_corr;
		end else begin
			p = (longint'(raw_i) * sens_state / P_SENS_DIV - off_state) / P_DIV;
			press_state = p[PRESS_W-1:0];
		end
		r.temp = temp_state;
		r.press = press_state;
		return r;
	endfunction

	function automatic int pick_gap_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [COEFF_W-1:0] pick_coeff();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 30)
			return '1;
		return COEFF_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return RAW_W'($urandom);
	endfunction

	// Half of the temperature readings land near the reference point, so that
	// both correction bands and the warm side are all reached.
	function automatic logic [RAW_W-1:0] pick_temp_raw();
		longint span, v;
		if ($urandom_range(0, 1))
			return pick_raw();
		span = (longint'(4000) << TEMP_SHIFT) / (longint'(cal[REG_TEMP_SLOPE]) + 1);
		if (span > RAW_MAX)
			span = RAW_MAX;
		v = longint'(cal[REG_REF_TEMP]) * REF_SCALE - span
			+ longint'($urandom_range(0, 32'(span + span / 4)));
		if (v < 0)
			v = 0;
		if (v > RAW_MAX)
			v = RAW_MAX;
		return v[RAW_W-1:0];
	endfunction

	task automatic write_cal(input logic [INDEX_W-1:0] idx, input logic [COEFF_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx <= REG_TEMP_SLOPE)
			cal[idx] = value;
		@(posedge clk);
	endtask

	task automatic load_cal_set(input logic [COEFF_W-1:0] set_i [NUM_CAL]);
		for (int i = 0; i < NUM_CAL; i++)
			write_cal(INDEX_W'(i), set_i[i]);
	endtask

	task automatic settle_block();
		sample_ch.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_reading(input logic kind_i, input logic [RAW_W-1:0] raw_i,
			input logic typed, input reading_result_t typed_res);
		int gap;
		reading_result_t predicted;
		gap = (gaps_on && $urandom_range(0, 99) < 35) ? pick_gap_len() : 0;
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.kind <= kind_i;
		sample_ch.raw_value <= raw_i;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		predicted = compensate_reading(kind_i, raw_i);
		pending_readings.push_back(typed ? typed_res : predicted);
	endtask

	always @(posedge clk) begin
		reading_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result transfer: temp %0d press %0d",
						result_ch.temperature_x100, result_ch.pressure_x100);
			end else begin
				want = pending_readings.pop_front();
				if (result_ch.temperature_x100 !== want.temp
						|| result_ch.pressure_x100 !== want.press) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: want temp %0d press %0d, got temp %0d press %0d",
							want.temp, want.press,
							result_ch.temperature_x100, result_ch.pressure_x100);
				end
			end
		end
		if (holds_done != hold_requests && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			holds_done++;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap--;
			result_ch.ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 99) < 25) begin
			rx_gap = pick_gap_len() - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	initial begin
		logic [1:0] cur_set;
		logic [COEFF_W-1:0] phase_set [NUM_CAL];
		logic k;

		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.kind <= KIND_TEMP;
		sample_ch.raw_value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_SENS;
		cfg_ch.data <= '0;
		for (int i = 0; i < NUM_CAL; i++)
			cal[i] = '0;
		off_state = 0;
		sens_state = 0;
		temp_state = '0;
		press_state = '0;

		cal_sets = '{
			'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
			'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
			'{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312}
		};

		directed_rows = '{
			'{KIND_PRESS, 24'h000000, 2'd0, 1'b1, '{20'sd0, 32'sd0}},
			'{KIND_PRESS, 24'hFFFFFF, 2'd0, 1'b1, '{20'sd0, 32'sd0}},
			'{KIND_TEMP,  24'h000000, 2'd0, 1'b1, '{20'sd2000, 32'sd0}},
			'{KIND_TEMP,  24'hFFFFFF, 2'd0, 1'b1, '{20'sd2000, 32'sd0}},
			'{KIND_PRESS, 24'hFFFFFF, 2'd0, 1'b1, '{20'sd2000, 32'sd0}},
			'{KIND_PRESS, 24'h000000, 2'd0, 1'b1, '{20'sd2000, 32'sd0}},
			'{KIND_TEMP,  24'h000000, 2'd1, 1'b0, '0},
			'{KIND_PRESS, 24'hFFFFFF, 2'd1, 1'b0, '0},
			'{KIND_PRESS, 24'h000000, 2'd1, 1'b0, '0},
			'{KIND_TEMP,  24'hFFFFFF, 2'd1, 1'b0, '0},
			'{KIND_PRESS, 24'hFFFFFF, 2'd1, 1'b0, '0},
			'{KIND_PRESS, 24'h000001, 2'd1, 1'b0, '0},
			'{KIND_TEMP,  24'hFFFF00, 2'd1, 1'b0, '0},
			'{KIND_PRESS, 24'h800000, 2'd1, 1'b0, '0},
			'{KIND_TEMP,  24'd8569150, 2'd2, 1'b0, '0},
			'{KIND_PRESS, 24'd9085466, 2'd2, 1'b0, '0},
			'{KIND_TEMP,  24'd7800000, 2'd2, 1'b0, '0},
			'{KIND_PRESS, 24'd9085466, 2'd2, 1'b0, '0},
			'{KIND_TEMP,  24'd7000000, 2'd2, 1'b0, '0},
			'{KIND_PRESS, 24'd9085466, 2'd2, 1'b0, '0},
			'{KIND_PRESS, 24'h000000, 2'd2, 1'b0, '0},
			'{KIND_TEMP,  24'h000000, 2'd2, 1'b0, '0},
			'{KIND_PRESS, 24'hFFFFFF, 2'd2, 1'b0, '0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		cur_set = 2'd0;
		for (int i = 0; i < DIRECTED_N; i++) begin
			if (directed_rows[i].cal_set != cur_set) begin
				settle_block();
				cur_set = directed_rows[i].cal_set;
				load_cal_set(cal_sets[cur_set]);
			end
			send_reading(directed_rows[i].kind, directed_rows[i].raw,
				directed_rows[i].typed, directed_rows[i].res);
		end

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			settle_block();
			for (int i = 0; i < NUM_CAL; i++)
				phase_set[i] = (phase == 0) ? '0 : (phase == 1) ? '1 : pick_coeff();
			load_cal_set(phase_set);
			write_cal(FIRST_UNUSED_INDEX + INDEX_W'($urandom_range(0, 1)), COEFF_W'($urandom));
			gaps_on = (phase % 3) != 2;
			if (phase == 1 || phase == 4)
				hold_requests++;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				k = $urandom_range(0, 1);
				send_reading(k, (k == KIND_TEMP) ? pick_temp_raw() : pick_raw(), 1'b0, '0);
			end
		end

		settle_block();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_readings.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
